### rtl/bcl_pkg.sv
// Shared types and constants for the bitplane cell-line pixel generator.
package bcl_pkg;

	localparam int CellAddrW   = 14;
	localparam int RowLineW    = 4;
	localparam int PlaneW      = 8;
	localparam int PixelW      = 3;
	localparam int PixelWordW  = 48;
	localparam int PixelCountW = 5;
	localparam int BlinkW      = 5;

	localparam int InDataW  = 48;
	localparam int OutDataW = 56;
	localparam int CfgIndexW = 3;
	localparam int CfgDataW  = 14;

	// Register indexes on the configuration channel.
	localparam logic [CfgIndexW-1:0] REG_DISPLAY_MODE      = 3'd0;
	localparam logic [CfgIndexW-1:0] REG_COLOR_SELECT      = 3'd1;
	localparam logic [CfgIndexW-1:0] REG_CURSOR_ADDRESS    = 3'd2;
	localparam logic [CfgIndexW-1:0] REG_CURSOR_FIRST_LINE = 3'd3;
	localparam logic [CfgIndexW-1:0] REG_CURSOR_BLINK_MODE = 3'd4;
	localparam logic [CfgIndexW-1:0] REG_CURSOR_DISABLE    = 3'd5;
	localparam logic [CfgIndexW-1:0] REG_DISPLAY_BLANK     = 3'd6;
	localparam logic [CfgIndexW-1:0] REG_TALL_ROWS         = 3'd7;

	// Cursor blink modes.
	localparam logic [1:0] BLINK_STEADY = 2'd0;
	localparam logic [1:0] BLINK_HIDDEN = 2'd1;
	localparam logic [1:0] BLINK_SLOW_3 = 2'd2;
	localparam logic [1:0] BLINK_SLOW_4 = 2'd3;

	// Input operations carried on tuser.
	localparam logic OP_RENDER = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic [7:0] COLOR_SELECT_RESET = 8'h70;
	localparam logic [PixelW-1:0] PIXEL_WHITE = 3'd7;
	localparam logic [PixelCountW-1:0] COUNT_EIGHTY = 5'd8;
	localparam logic [PixelCountW-1:0] COUNT_FORTY  = 5'd16;

	typedef struct packed {
		logic [4:0]           display_mode;
		logic [7:0]           color_select;
		logic [CellAddrW-1:0] cursor_address;
		logic [4:0]           cursor_first_line;
		logic [1:0]           cursor_blink_mode;
		logic                 cursor_disable;
		logic                 display_blank;
		logic                 tall_rows;
	} bcl_cfg_t;

endpackage

### rtl/bitplane_cell_line_pixel_generator.sv
// Top level of the bitplane cell-line pixel generator.
// One item per clock while the output side keeps taking results: each
// render item is held in the input register, where the renderer turns it
// into a result that lands in the output register as the item leaves. A
// frame tick item advances the blink counter as it leaves the input register
// and gives no result. Configuration writes take effect at once and are
// always accepted.
module bitplane_cell_line_pixel_generator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// cell_address[13:0], row_line[17:14], blue_byte[25:18], red_byte[33:26],
	// green_byte[41:34], zero padding[47:42]
	input  logic [bcl_pkg::InDataW-1:0]        s_tdata,
	// operation[0]
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// pixel_word[47:0], pixel_count[52:48], zero padding[55:53]
	output logic [bcl_pkg::OutDataW-1:0]       m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bcl_pkg::CfgIndexW-1:0]      cfg_index,
	input  logic [bcl_pkg::CfgDataW-1:0]       cfg_data
);
	import bcl_pkg::*;

	bcl_cfg_t                cfg_q;
	logic [BlinkW-1:0]       blink_q;
	logic                    valid_s1;
	logic                    op_s1;
	logic [InDataW-1:0]      data_s1;
	logic                    out_free;
	logic                    advance_s1;
	logic [PixelWordW-1:0]   pixel_word;
	logic [PixelCountW-1:0]  pixel_count;
	logic [OutDataW-1:0]     out_q;
	logic                    out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.display_mode      <= '0;
			cfg_q.color_select      <= COLOR_SELECT_RESET;
			cfg_q.cursor_address    <= '0;
			cfg_q.cursor_first_line <= '0;
			cfg_q.cursor_blink_mode <= BLINK_STEADY;
			cfg_q.cursor_disable    <= 1'b0;
			cfg_q.display_blank     <= 1'b0;
			cfg_q.tall_rows         <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DISPLAY_MODE:      cfg_q.display_mode      <= cfg_data[4:0];
				REG_COLOR_SELECT:      cfg_q.color_select      <= cfg_data[7:0];
				REG_CURSOR_ADDRESS:    cfg_q.cursor_address    <= cfg_data[CellAddrW-1:0];
				REG_CURSOR_FIRST_LINE: cfg_q.cursor_first_line <= cfg_data[4:0];
				REG_CURSOR_BLINK_MODE: cfg_q.cursor_blink_mode <= cfg_data[1:0];
				REG_CURSOR_DISABLE:    cfg_q.cursor_disable    <= cfg_data[0];
				REG_DISPLAY_BLANK:     cfg_q.display_blank     <= cfg_data[0];
				REG_TALL_ROWS:         cfg_q.tall_rows         <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A tick leaves the input register unconditionally; a render needs room ahead.
	assign out_free   = !out_valid_q || m_tready;
	assign advance_s1 = valid_s1 && ((op_s1 == OP_TICK) || out_free);
	assign s_tready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tuser;
			data_s1 <= s_tdata;
		end
	end

	// The counter moves only when the tick passes, so renders ahead of it
	// see the old value and renders behind it the new one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_q <= '0;
		end else if (advance_s1 && (op_s1 == OP_TICK)) begin
			blink_q <= blink_q + BlinkW'(1);
		end
	end

	bcl_render u_render (
		.cfg           (cfg_q),
		.blink_counter (blink_q),
		.cell_address  (data_s1[13:0]),
		.row_line      (data_s1[17:14]),
		.blue_byte     (data_s1[25:18]),
		.red_byte      (data_s1[33:26]),
		.green_byte    (data_s1[41:34]),
		.pixel_word    (pixel_word),
		.pixel_count   (pixel_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && (op_s1 == OP_RENDER)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && (op_s1 == OP_RENDER)) begin
			out_q <= {3'b000, pixel_count, pixel_word};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

### rtl/bcl_render.sv
// Combinational renderer: plane bytes and cursor state to one line of pixels.
module bcl_render (
	input  bcl_pkg::bcl_cfg_t                     cfg,
	input  logic [bcl_pkg::BlinkW-1:0]            blink_counter,
	input  logic [bcl_pkg::CellAddrW-1:0]         cell_address,
	input  logic [bcl_pkg::RowLineW-1:0]          row_line,
	input  logic [bcl_pkg::PlaneW-1:0]            blue_byte,
	input  logic [bcl_pkg::PlaneW-1:0]            red_byte,
	input  logic [bcl_pkg::PlaneW-1:0]            green_byte,
	output logic [bcl_pkg::PixelWordW-1:0]        pixel_word,
	output logic [bcl_pkg::PixelCountW-1:0]       pixel_count
);
	import bcl_pkg::*;

	logic              forty;
	logic              active;
	logic              blink_on;
	logic              cursor_hit;
	logic [PlaneW-1:0] b, r, g, merged;
	logic [PixelW-1:0] cursor_pix;
	logic [PixelW-1:0] px [8];

	assign forty  = cfg.display_mode[3];
	assign active = !cfg.display_blank && (cfg.display_mode[2:0] != 3'd0);

	always_comb begin
		unique case (cfg.cursor_blink_mode)
			BLINK_STEADY: blink_on = 1'b1;
			BLINK_HIDDEN: blink_on = 1'b0;
			BLINK_SLOW_3: blink_on = blink_counter[3];
			BLINK_SLOW_4: blink_on = blink_counter[4];
			default:      blink_on = 1'b0;
		endcase
	end

	always_comb begin
		merged = '0;
		if (!active) begin
			b = '0;
			r = '0;
			g = '0;
		end else if (cfg.tall_rows) begin
			// Sixteen-line rows: top half from blue, bottom half from red, as white.
			b = row_line[3] ? red_byte : blue_byte;
			r = b;
			g = b;
		end else begin
			b = cfg.display_mode[2] ? blue_byte  : '0;
			r = cfg.display_mode[1] ? red_byte   : '0;
			g = cfg.display_mode[0] ? green_byte : '0;
			if (cfg.display_mode[4]) begin
				merged = b | r | g;
				b = merged;
				r = merged;
				g = merged;
			end
		end
	end

	// With eight-line rows the cursor never reaches lines eight and above.
	assign cursor_hit = active && (cell_address == cfg.cursor_address)
		&& !cfg.cursor_disable && blink_on
		&& ({1'b0, row_line} >= cfg.cursor_first_line)
		&& (cfg.tall_rows || !row_line[3]);

	assign cursor_pix = cfg.color_select[7] ? PIXEL_WHITE : cfg.color_select[6:4];

	always_comb begin
		pixel_word = '0;
		for (int i = 0; i < 8; i++) begin
			px[i] = cursor_hit ? cursor_pix : {g[i], r[i], b[i]};
			if (forty) begin
				pixel_word[2*PixelW*i +: 2*PixelW] = {px[i], px[i]};
			end else begin
				pixel_word[PixelW*i +: PixelW] = px[i];
			end
		end
	end

	assign pixel_count = forty ? COUNT_FORTY : COUNT_EIGHTY;

endmodule

### rtl/bcl_checker.sv
// Port-level checker for the pixel generator, bound to the top level.
module bcl_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [bcl_pkg::OutDataW-1:0] m_tdata
);
	import bcl_pkg::*;

	// A result that is not taken stays offered unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or vanished while stalled");

	// An empty output register always leaves room for a new item.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled although the output register is empty");

	a_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[52:48] == COUNT_EIGHTY) || (m_tdata[52:48] == COUNT_FORTY))
		else $error("pixel count is neither eight nor sixteen");

	// In eighty-column mode only the lower eight pixels are used.
	a_eighty_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[52:48] == COUNT_EIGHTY) |-> (m_tdata[47:24] == 24'd0))
		else $error("unused pixels set in eighty-column mode");

endmodule

bind bitplane_cell_line_pixel_generator bcl_checker u_bcl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### tb/bitplane_cell_line_pixel_generator_test.sv
// Self-checking testbench for the bitplane cell-line pixel generator.
module bitplane_cell_line_pixel_generator_test;
	import bcl_pkg::*;

	typedef struct packed {
		logic [PixelWordW-1:0]  word;
		logic [PixelCountW-1:0] count;
	} pixel_line_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [InDataW-1:0]   s_tdata = '0;
	logic                 s_tuser = OP_RENDER;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OutDataW-1:0]  m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CfgIndexW-1:0] cfg_index = REG_DISPLAY_MODE;
	logic [CfgDataW-1:0]  cfg_data = '0;

	// Copy of the block's registers and blink counter, as seen by the predictor.
	bcl_cfg_t          shadow_cfg = '{display_mode: '0, color_select: COLOR_SELECT_RESET,
		cursor_address: '0, cursor_first_line: '0, cursor_blink_mode: BLINK_STEADY,
		cursor_disable: 1'b0, display_blank: 1'b0, tall_rows: 1'b0};
	logic [BlinkW-1:0] blink_count = '0;

	pixel_line_t expected_lines[$];

	int mismatches = 0;
	int render_count = 0;
	int tick_count = 0;
	int checked_count = 0;
	int cursor_lines = 0;
	int settings_count = 0;

	// Sender burst control and receiver stall control.
	bit gaps_enabled = 1'b1;
	int burst_left = 0;
	int hold_request = 0;
	int hold_left = 0;
	int rx_mode = 0;
	int rx_cycle = 0;

	bitplane_cell_line_pixel_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void render_cell_line(input logic [CellAddrW-1:0] addr,
		input logic [RowLineW-1:0] line, input logic [PlaneW-1:0] b_in,
		input logic [PlaneW-1:0] r_in, input logic [PlaneW-1:0] g_in,
		output pixel_line_t res, output logic hit);
		logic [PlaneW-1:0] pb, pr, pg, v;
		logic [PixelW-1:0] px [8];
		logic [PixelW-1:0] colour;
		logic              forty, active, shows;
		int                row_height;
		pb = b_in;
		pr = r_in;
		pg = g_in;
		forty = shadow_cfg.display_mode[3];
		active = !shadow_cfg.display_blank && (shadow_cfg.display_mode[2:0] != 3'd0);
		row_height = shadow_cfg.tall_rows ? 16 : 8;
		if (!active) begin
			pb = '0;
			pr = '0;
			pg = '0;
		end else if (shadow_cfg.tall_rows) begin
			// Tall rows ignore the plane enables: blue on top, red below, both white.
			v = (line < 8) ? pb : pr;
			pb = v;
			pr = v;
			pg = v;
		end else begin
			if (!shadow_cfg.display_mode[2]) pb = '0;
			if (!shadow_cfg.display_mode[1]) pr = '0;
			if (!shadow_cfg.display_mode[0]) pg = '0;
			if (shadow_cfg.display_mode[4]) begin
				v = pb | pr | pg;
				pb = v;
				pr = v;
				pg = v;
			end
		end
		for (int i = 0; i < 8; i++)
			px[i] = {pg[i], pr[i], pb[i]};
		case (shadow_cfg.cursor_blink_mode)
			BLINK_STEADY: shows = 1'b1;
			BLINK_SLOW_3: shows = blink_count[3];
			BLINK_SLOW_4: shows = blink_count[4];
			default:      shows = 1'b0;
		endcase
		hit = active && (addr == shadow_cfg.cursor_address) && !shadow_cfg.cursor_disable &&
			shows && (int'(line) >= int'(shadow_cfg.cursor_first_line)) &&
			(int'(line) < row_height);
		if (hit) begin
			colour = shadow_cfg.color_select[7] ? PIXEL_WHITE : shadow_cfg.color_select[6:4];
			for (int i = 0; i < 8; i++)
				px[i] = colour;
		end
		res.word = '0;
		for (int i = 0; i < 8; i++) begin
			if (forty) begin
				res.word[6*i +: 3] = px[i];
				res.word[6*i+3 +: 3] = px[i];
			end else begin
				res.word[3*i +: 3] = px[i];
			end
		end
		res.count = forty ? COUNT_FORTY : COUNT_EIGHTY;
	endfunction

	// Receiver: checks each result against the oldest prediction and decides
	// tready for the next cycle.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_lines.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, actual word %h count %0d", $time,
					m_tdata[PixelWordW-1:0], m_tdata[PixelWordW +: PixelCountW]);
			end else begin
				pixel_line_t want;
				want = expected_lines.pop_front();
				checked_count++;
				if (m_tdata[PixelWordW-1:0] !== want.word) begin
					mismatches++;
					$display("%0t: pixel_word mismatch, expected %h actual %h", $time,
						want.word, m_tdata[PixelWordW-1:0]);
				end
				if (m_tdata[PixelWordW +: PixelCountW] !== want.count) begin
					mismatches++;
					$display("%0t: pixel_count mismatch, expected %0d actual %0d", $time,
						want.count, m_tdata[PixelWordW +: PixelCountW]);
				end
			end
		end
		rx_cycle++;
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (rx_cycle % 256 == 0)
			rx_mode = $urandom_range(0, 2);
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= (rx_cycle % 7 != 3) && (rx_cycle % 5 != 0);
			endcase
		end
	end

	task automatic send_item(input logic op, input logic [CellAddrW-1:0] addr,
		input logic [RowLineW-1:0] line, input logic [PlaneW-1:0] b,
		input logic [PlaneW-1:0] r, input logic [PlaneW-1:0] g);
		int          gap;
		pixel_line_t predicted;
		logic        hit;
		gap = 0;
		if (gaps_enabled) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				gap = $urandom_range(0, 5);
			end
			burst_left--;
		end
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'd0, g, r, b, line, addr};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op == OP_TICK) begin
			blink_count = blink_count + BlinkW'(1);
			tick_count++;
		end else begin
			render_cell_line(addr, line, b, r, g, predicted, hit);
			expected_lines.push_back(predicted);
			render_count++;
			if (hit) cursor_lines++;
		end
	endtask

	task automatic render(input logic [CellAddrW-1:0] addr, input logic [RowLineW-1:0] line,
		input logic [PlaneW-1:0] b, input logic [PlaneW-1:0] r, input logic [PlaneW-1:0] g);
		send_item(OP_RENDER, addr, line, b, r, g);
	endtask

	// Lowers tvalid, lets every expected result arrive and gives any frame
	// tick still in flight time to reach the blink counter.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_lines.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_DISPLAY_MODE:      shadow_cfg.display_mode = value[4:0];
			REG_COLOR_SELECT:      shadow_cfg.color_select = value[7:0];
			REG_CURSOR_ADDRESS:    shadow_cfg.cursor_address = value[CellAddrW-1:0];
			REG_CURSOR_FIRST_LINE: shadow_cfg.cursor_first_line = value[4:0];
			REG_CURSOR_BLINK_MODE: shadow_cfg.cursor_blink_mode = value[1:0];
			REG_CURSOR_DISABLE:    shadow_cfg.cursor_disable = value[0];
			REG_DISPLAY_BLANK:     shadow_cfg.display_blank = value[0];
			default:               shadow_cfg.tall_rows = value[0];
		endcase
	endtask

	task automatic apply_setting(input bcl_cfg_t c);
		wait_idle();
		write_reg(REG_DISPLAY_MODE, CfgDataW'(c.display_mode));
		write_reg(REG_COLOR_SELECT, CfgDataW'(c.color_select));
		write_reg(REG_CURSOR_ADDRESS, CfgDataW'(c.cursor_address));
		write_reg(REG_CURSOR_FIRST_LINE, CfgDataW'(c.cursor_first_line));
		write_reg(REG_CURSOR_BLINK_MODE, CfgDataW'(c.cursor_blink_mode));
		write_reg(REG_CURSOR_DISABLE, CfgDataW'(c.cursor_disable));
		write_reg(REG_DISPLAY_BLANK, CfgDataW'(c.display_blank));
		write_reg(REG_TALL_ROWS, CfgDataW'(c.tall_rows));
		cfg_valid <= 1'b0;
		settings_count++;
	endtask

	function automatic bcl_cfg_t plain_setting(input logic [4:0] mode);
		bcl_cfg_t c;
		c = '0;
		c.display_mode = mode;
		c.color_select = COLOR_SELECT_RESET;
		c.cursor_disable = 1'b1;
		return c;
	endfunction

	function automatic int unsigned pick(input int unsigned maxv);
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return maxv;
			default: return $urandom_range(0, maxv);
		endcase
	endfunction

	task automatic test_power_on_state();
		// No plane is enabled after reset, so even the cursor cell is black.
		render(14'h0000, 4'd0, 8'hff, 8'hff, 8'hff);
	endtask

	task automatic test_plane_mixing();
		apply_setting(plain_setting(5'b00111));
		render(14'h3fff, 4'd15, 8'hff, 8'hff, 8'hff);
		render(14'h0001, 4'd0, 8'ha5, 8'h3c, 8'h0f);
		apply_setting(plain_setting(5'b00100));
		render(14'h0002, 4'd1, 8'ha5, 8'h3c, 8'h0f);
		apply_setting(plain_setting(5'b00010));
		render(14'h0003, 4'd2, 8'ha5, 8'h3c, 8'h0f);
		apply_setting(plain_setting(5'b00001));
		render(14'h0004, 4'd3, 8'ha5, 8'h3c, 8'h0f);
		apply_setting(plain_setting(5'b10101));
		render(14'h0005, 4'd4, 8'h81, 8'h3c, 8'h10);
		apply_setting(plain_setting(5'b01111));
		render(14'h0006, 4'd5, 8'ha5, 8'h3c, 8'h0f);
		apply_setting(plain_setting(5'b11111));
		render(14'h0007, 4'd6, 8'h00, 8'h00, 8'h80);
	endtask

	task automatic test_tall_rows();
		bcl_cfg_t c;
		c = plain_setting(5'b01001);
		c.tall_rows = 1'b1;
		apply_setting(c);
		render(14'h0100, 4'd0, 8'ha5, 8'h5a, 8'hff);
		render(14'h0100, 4'd7, 8'ha5, 8'h5a, 8'hff);
		render(14'h0100, 4'd8, 8'ha5, 8'h5a, 8'hff);
		render(14'h0100, 4'd15, 8'ha5, 8'h5a, 8'hff);
	endtask

	task automatic test_cursor();
		bcl_cfg_t c;
		c = plain_setting(5'b00111);
		c.cursor_disable = 1'b0;
		c.cursor_address = 14'h3fff;
		c.cursor_first_line = 5'd3;
		c.color_select = 8'h50;
		apply_setting(c);
		render(14'h3fff, 4'd2, 8'h12, 8'h34, 8'h56);
		render(14'h3fff, 4'd3, 8'h12, 8'h34, 8'h56);
		// Lines past an eight-line row are drawn but never carry the cursor.
		render(14'h3fff, 4'd15, 8'h12, 8'h34, 8'h56);
		render(14'h3ffe, 4'd5, 8'h12, 8'h34, 8'h56);
		c.color_select = 8'h80;
		c.cursor_first_line = 5'd0;
		apply_setting(c);
		render(14'h3fff, 4'd0, 8'h00, 8'h00, 8'h00);
		c.cursor_first_line = 5'd8;
		apply_setting(c);
		render(14'h3fff, 4'd8, 8'h00, 8'h00, 8'h00);
		c.tall_rows = 1'b1;
		c.cursor_first_line = 5'd16;
		apply_setting(c);
		render(14'h3fff, 4'd15, 8'hf0, 8'h0f, 8'h00);
		c.cursor_first_line = 5'd12;
		apply_setting(c);
		render(14'h3fff, 4'd12, 8'hf0, 8'h0f, 8'h00);
		c.tall_rows = 1'b0;
		c.cursor_first_line = 5'd0;
		c.cursor_blink_mode = BLINK_HIDDEN;
		apply_setting(c);
		render(14'h3fff, 4'd1, 8'h00, 8'h00, 8'h00);
		c.cursor_blink_mode = BLINK_STEADY;
		c.cursor_disable = 1'b1;
		apply_setting(c);
		render(14'h3fff, 4'd1, 8'h00, 8'h00, 8'h00);
		c.cursor_disable = 1'b0;
		c.display_blank = 1'b1;
		apply_setting(c);
		render(14'h3fff, 4'd1, 8'hff, 8'hff, 8'hff);
		c.display_blank = 1'b0;
		c.cursor_blink_mode = BLINK_SLOW_3;
		apply_setting(c);
		send_item(OP_TICK, 14'h3fff, 4'd15, 8'hff, 8'hff, 8'hff);
		render(14'h3fff, 4'd1, 8'h00, 8'h00, 8'h00);
	endtask

	task automatic test_input_stall();
		apply_setting(plain_setting(5'b01111));
		gaps_enabled = 1'b0;
		// The receiver holds off while items keep coming, so the block must
		// fill up and drop s_tready.
		hold_request = 64;
		repeat (40)
			render(CellAddrW'($urandom_range(0, 16383)), RowLineW'($urandom_range(0, 15)),
				PlaneW'($urandom_range(0, 255)), PlaneW'($urandom_range(0, 255)),
				PlaneW'($urandom_range(0, 255)));
		gaps_enabled = 1'b1;
	endtask

	task automatic test_random_traffic();
		bcl_cfg_t c;
		logic     op;
		logic [CellAddrW-1:0] addr;
		for (int phase = 0; phase < 10; phase++) begin
			if (phase == 0) begin
				c.display_mode = 5'h1f;
				c.color_select = 8'hff;
				c.cursor_address = 14'h3fff;
				c.cursor_first_line = 5'h1f;
				c.cursor_blink_mode = BLINK_SLOW_4;
				c.cursor_disable = 1'b0;
				c.display_blank = 1'b0;
				c.tall_rows = 1'b1;
			end else begin
				c.display_mode = 5'(pick(31));
				c.color_select = 8'(pick(255));
				c.cursor_address = CellAddrW'(pick(16383));
				c.cursor_first_line = ($urandom_range(0, 3) == 0) ? 5'(pick(31))
					: 5'($urandom_range(0, 15));
				c.cursor_blink_mode = 2'($urandom_range(0, 3));
				c.cursor_disable = ($urandom_range(0, 3) == 0);
				c.display_blank = ($urandom_range(0, 4) == 0);
				c.tall_rows = 1'($urandom_range(0, 1));
			end
			apply_setting(c);
			gaps_enabled = ($urandom_range(0, 3) != 0);
			repeat (100) begin
				op = ($urandom_range(0, 5) == 0) ? OP_TICK : OP_RENDER;
				addr = ($urandom_range(0, 1) == 0) ? shadow_cfg.cursor_address
					: CellAddrW'(pick(16383));
				send_item(op, addr, RowLineW'($urandom_range(0, 15)), PlaneW'(pick(255)),
					PlaneW'(pick(255)), PlaneW'(pick(255)));
			end
		end
		gaps_enabled = 1'b1;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_on_state();
		test_plane_mixing();
		test_tall_rows();
		test_cursor();
		test_input_stall();
		test_random_traffic();
		wait_idle();
		$display("Covered %0d cell lines and %0d frame ticks over %0d register settings.",
			render_count, tick_count, settings_count);
		$display("Checked %0d results, %0d of them on cursor lines.", checked_count,
			cursor_lines);
		if (mismatches == 0 && expected_lines.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out with %0d results outstanding.", expected_lines.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
